/* src/sorted_queue_with_tie_numbering_defines.svh */
// Assertion macros for the sorted queue with tie numbering.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef SORTED_QUEUE_WITH_TIE_NUMBERING_DEFINES_SVH
`define SORTED_QUEUE_WITH_TIE_NUMBERING_DEFINES_SVH

`ifndef SYNTHESIS
`define SQTN_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SQTN_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SQTN_ASSERT_IMP(label, ante, cons)
`define SQTN_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* src/sqtn_pkg.sv */
package sqtn_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_BITS  = 32;
    localparam int DATA_W    = 32;
    localparam int TIE_W     = 6;
    localparam int OUT_POS_W = 6;
    localparam int OUT_CNT_W = 7;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic [TIE_W-1:0] TIE_MAX = {TIE_W{1'b1}};

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_POP_RD,
        S_POP_CAP,
        S_PULL_RD,
        S_PULL_WR,
        S_POP_END,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [DATA_W-1:0]   payload;
        logic [TIE_W-1:0]    tie;
    } t_entry;

    typedef struct packed {
        t_func               func;
        logic [KEY_BITS-1:0] key;
        logic [DATA_W-1:0]   payload;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [DATA_W-1:0]    head_payload;
        logic [TIE_W-1:0]     tie;
        logic [OUT_POS_W-1:0] pos;
        logic                 eq;
        logic [OUT_CNT_W-1:0] count;
    } t_res;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
        logic             tied;
        logic [IDX_W-1:0] tied_pos;
    } t_stat;

endpackage

/* src/sorted_queue_with_tie_numbering.sv */
// Channel   Direction  Handshake              Contents
// s stream  in         i_s_tvalid/o_s_tready  operation, key and payload
// m stream  out        o_m_tvalid/i_m_tready  status, head payload, tie, position, count
// cfg       in         i_cfg_valid/o_cfg_ready descending order flag
//
// An insert scans the held entries from the head to find its place p, then moves each entry
// from p onward up one place to open a gap; a remove takes the head and moves each entry behind it down one.
// The entry memory has one read port and one write port, so every entry moved takes its own read and write.
// Reset is synchronous and needs no clearing pass; entries are read only below the count.
// A result waiting in the output register does not hold back the next transfer in.
`include "sorted_queue_with_tie_numbering_defines.svh"

module sorted_queue_with_tie_numbering (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // sort_key, payload
    input  logic [0:0]  i_s_tuser,   // func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // head_payload, tie_number, insert_position,
                                     // key_was_equal, entry_count, zero fill
    output logic [1:0]  o_m_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data   // descending_order
);

    logic            r_desc;
    sqtn_pkg::t_req  req;
    sqtn_pkg::t_res  res;
    sqtn_pkg::t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
        end else if (i_cfg_valid) begin
            r_desc <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    assign req = '{func:    sqtn_pkg::t_func'(i_s_tuser[0]),
                   key:     i_s_tdata[sqtn_pkg::KEY_BITS-1:0],
                   payload: i_s_tdata[63:32]};

    sqtn_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (r_desc),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res),
        .o_stat      (stat)
    );

    assign o_m_tdata = {4'b0000, res.count, res.eq, res.pos, res.tie, res.head_payload};
    assign o_m_tuser = res.status;

    `SQTN_ASSERT_IMP(a_tied_in_range, stat.tied, stat.tied_pos < stat.count)
    `SQTN_ASSERT_IMP(a_count_bound, 1'b1, stat.count <= sqtn_pkg::CNT_W'(sqtn_pkg::CAPACITY))
    `SQTN_ASSERT_NXT(a_busy_after_transfer, i_s_tvalid && o_s_tready, !o_s_tready && stat.busy)
    `SQTN_ASSERT_NXT(a_count_idle, o_s_tready && !i_s_tvalid, $stable(stat.count))

endmodule

/* src/sqtn_core.sv */
module sqtn_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_desc,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  sqtn_pkg::t_req i_req,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output sqtn_pkg::t_res o_res,
    output sqtn_pkg::t_stat o_stat
);

    localparam logic [sqtn_pkg::CNT_W-1:0] ONE  = sqtn_pkg::CNT_W'(1);
    localparam logic [sqtn_pkg::CNT_W-1:0] FULL = sqtn_pkg::CNT_W'(sqtn_pkg::CAPACITY);

    sqtn_pkg::t_entry r_mem [sqtn_pkg::CAPACITY];
    sqtn_pkg::t_entry r_rd_data;

    sqtn_pkg::t_state r_state, n_state;
    sqtn_pkg::t_req   r_req, n_req;
    sqtn_pkg::t_status r_status, n_status;
    sqtn_pkg::t_res   r_out, n_out;
    logic [sqtn_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [sqtn_pkg::CNT_W-1:0]  r_p, n_p;
    logic [sqtn_pkg::CNT_W-1:0]  r_count, n_count;
    logic [sqtn_pkg::TIE_W-1:0]  r_tie, n_tie;
    logic                        r_eq, n_eq;
    logic [sqtn_pkg::DATA_W-1:0] r_head, n_head;
    logic                        r_tied, n_tied;
    logic [sqtn_pkg::IDX_W-1:0]  r_tied_pos, n_tied_pos;
    logic                        r_out_valid, n_out_valid;

    logic                        mem_we;
    logic [sqtn_pkg::IDX_W-1:0]  mem_wr_addr;
    logic [sqtn_pkg::IDX_W-1:0]  mem_rd_addr;
    sqtn_pkg::t_entry            mem_wr_data;

    logic [sqtn_pkg::CNT_W-1:0]  idx_p1, idx_m1;
    logic                        req_fire, goes_before, key_eq, out_free;
    logic [sqtn_pkg::TIE_W-1:0]  tie_next;

    assign idx_p1   = r_idx + ONE;
    assign idx_m1   = r_idx - ONE;
    assign req_fire = i_req_valid && (r_state == sqtn_pkg::S_IDLE);
    assign key_eq   = (r_req.key == r_rd_data.key);
    assign goes_before = i_desc ? (r_req.key >= r_rd_data.key)
                                : (r_req.key <= r_rd_data.key);
    assign tie_next = (r_rd_data.tie >= sqtn_pkg::TIE_MAX) ? sqtn_pkg::TIE_MAX
                                                          : r_rd_data.tie + 1'b1;
    assign out_free = !r_out_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        r_rd_data <= r_mem[mem_rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sqtn_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.func == sqtn_pkg::FUNC_INSERT) begin
                        if (r_count == FULL) begin
                            n_state = sqtn_pkg::S_FIN;
                        end else if (r_count == '0) begin
                            n_state = sqtn_pkg::S_PUT;
                        end else begin
                            n_state = sqtn_pkg::S_SCAN_RD;
                        end
                    end else if (r_count == '0) begin
                        n_state = sqtn_pkg::S_FIN;
                    end else begin
                        n_state = sqtn_pkg::S_POP_RD;
                    end
                end
            end
            sqtn_pkg::S_SCAN_RD:  n_state = sqtn_pkg::S_SCAN_CMP;
            sqtn_pkg::S_SCAN_CMP: begin
                if (goes_before) begin
                    n_state = sqtn_pkg::S_SHIFT_RD;
                end else if (idx_p1 == r_count) begin
                    n_state = sqtn_pkg::S_PUT;
                end else begin
                    n_state = sqtn_pkg::S_SCAN_RD;
                end
            end
            sqtn_pkg::S_SHIFT_RD: n_state = sqtn_pkg::S_SHIFT_WR;
            sqtn_pkg::S_SHIFT_WR: begin
                if (idx_m1 == r_p) begin
                    n_state = sqtn_pkg::S_PUT;
                end else begin
                    n_state = sqtn_pkg::S_SHIFT_RD;
                end
            end
            sqtn_pkg::S_PUT:    n_state = sqtn_pkg::S_FIN;
            sqtn_pkg::S_POP_RD: n_state = sqtn_pkg::S_POP_CAP;
            sqtn_pkg::S_POP_CAP: begin
                if (r_count == ONE) begin
                    n_state = sqtn_pkg::S_POP_END;
                end else begin
                    n_state = sqtn_pkg::S_PULL_RD;
                end
            end
            sqtn_pkg::S_PULL_RD: n_state = sqtn_pkg::S_PULL_WR;
            sqtn_pkg::S_PULL_WR: begin
                if (idx_p1 == r_count) begin
                    n_state = sqtn_pkg::S_POP_END;
                end else begin
                    n_state = sqtn_pkg::S_PULL_RD;
                end
            end
            sqtn_pkg::S_POP_END: n_state = sqtn_pkg::S_FIN;
            sqtn_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = sqtn_pkg::S_IDLE;
                end
            end
            default: n_state = sqtn_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        mem_we      = 1'b0;
        mem_wr_addr = r_idx[sqtn_pkg::IDX_W-1:0];
        mem_rd_addr = r_idx[sqtn_pkg::IDX_W-1:0];
        mem_wr_data = r_rd_data;
        case (r_state)
            sqtn_pkg::S_SHIFT_RD: mem_rd_addr = idx_m1[sqtn_pkg::IDX_W-1:0];
            sqtn_pkg::S_SHIFT_WR: mem_we = 1'b1;
            sqtn_pkg::S_PUT: begin
                mem_we      = 1'b1;
                mem_wr_addr = r_p[sqtn_pkg::IDX_W-1:0];
                mem_wr_data = '{key: r_req.key, payload: r_req.payload, tie: r_tie};
            end
            sqtn_pkg::S_POP_RD: mem_rd_addr = '0;
            sqtn_pkg::S_PULL_WR: begin
                mem_we      = 1'b1;
                mem_wr_addr = idx_m1[sqtn_pkg::IDX_W-1:0];
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_comb begin
        n_req       = r_req;
        n_status    = r_status;
        n_idx       = r_idx;
        n_p         = r_p;
        n_count     = r_count;
        n_tie       = r_tie;
        n_eq        = r_eq;
        n_head      = r_head;
        n_tied      = r_tied;
        n_tied_pos  = r_tied_pos;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;
        case (r_state)
            sqtn_pkg::S_IDLE: begin
                if (req_fire) begin
                    n_req    = i_req;
                    n_idx    = '0;
                    n_p      = '0;
                    n_tie    = '0;
                    n_eq     = 1'b0;
                    n_head   = '0;
                    n_status = sqtn_pkg::ST_OK;
                    if (i_req.func == sqtn_pkg::FUNC_INSERT) begin
                        if (r_count == FULL) begin
                            n_status = sqtn_pkg::ST_FULL;
                        end
                    end else if (r_count == '0) begin
                        n_status = sqtn_pkg::ST_EMPTY;
                    end
                end
            end
            sqtn_pkg::S_SCAN_CMP: begin
                if (goes_before) begin
                    n_p   = r_idx;
                    n_idx = r_count;
                    if (key_eq) begin
                        n_eq  = 1'b1;
                        n_tie = tie_next;
                    end
                end else if (idx_p1 == r_count) begin
                    n_p = r_count;
                end else begin
                    n_idx = idx_p1;
                end
            end
            sqtn_pkg::S_SHIFT_WR: n_idx = idx_m1;
            sqtn_pkg::S_PUT: begin
                n_count = r_count + ONE;
                n_tied  = r_eq;
                if (r_eq) begin
                    n_tied_pos = r_p[sqtn_pkg::IDX_W-1:0];
                end
            end
            sqtn_pkg::S_POP_CAP: begin
                n_head = r_rd_data.payload;
                n_tie  = r_rd_data.tie;
                n_idx  = ONE;
            end
            sqtn_pkg::S_PULL_WR: n_idx = idx_p1;
            sqtn_pkg::S_POP_END: begin
                n_count = r_count - ONE;
                if (r_tied) begin
                    if (r_tied_pos == '0) begin
                        n_tied = 1'b0;
                    end else begin
                        n_tied_pos = r_tied_pos - 1'b1;
                    end
                end
            end
            sqtn_pkg::S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{status:       r_status,
                              head_payload: r_head,
                              tie:          r_tie,
                              pos:          sqtn_pkg::OUT_POS_W'(r_p),
                              eq:           r_eq,
                              count:        sqtn_pkg::OUT_CNT_W'(r_count)};
                end
            end
            default: n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sqtn_pkg::S_IDLE;
            r_count     <= '0;
            r_tied      <= 1'b0;
            r_tied_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_tied      <= n_tied;
            r_tied_pos  <= n_tied_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_p      <= n_p;
        r_tie    <= n_tie;
        r_eq     <= n_eq;
        r_head   <= n_head;
        r_out    <= n_out;
    end

    assign o_req_ready = (r_state == sqtn_pkg::S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_stat      = '{busy:     (r_state != sqtn_pkg::S_IDLE),
                           count:    r_count,
                           tied:     r_tied,
                           tied_pos: r_tied_pos};

endmodule

/* tb/sorted_queue_with_tie_numbering_tb.sv */
module sorted_queue_with_tie_numbering_tb;
    timeunit 1ns;
    timeprecision 1ps;

    class queue_tracker;
        bit               descending;
        sqtn_pkg::t_entry held[$];
        sqtn_pkg::t_res   awaited[$];
        int               mismatches;
        int               results;
        int               inserts;
        int               removes;
        int               fulls;
        int               empties;
        int               ties;
        int               top_tie;

        function void set_order(bit desc);
            descending = desc;
        endfunction

        function void note_request(sqtn_pkg::t_func func,
                                   logic [sqtn_pkg::KEY_BITS-1:0] key,
                                   logic [sqtn_pkg::DATA_W-1:0] payload);
            sqtn_pkg::t_res   r;
            sqtn_pkg::t_entry e;
            int               n;
            int               p;
            r = '0;
            r.status = sqtn_pkg::ST_OK;
            n = held.size();
            if (func == sqtn_pkg::FUNC_INSERT) begin
                inserts++;
                if (n >= sqtn_pkg::CAPACITY) begin
                    r.status = sqtn_pkg::ST_FULL;
                    fulls++;
                end else begin
                    p = n;
                    for (int i = 0; i < n; i++) begin
                        if (p == n && (descending ? key >= held[i].key : key <= held[i].key))
                            p = i;
                    end
                    e.key = key;
                    e.payload = payload;
                    e.tie = '0;
                    if (p < n && held[p].key == key) begin
                        r.eq = 1'b1;
                        e.tie = (held[p].tie == sqtn_pkg::TIE_MAX) ? sqtn_pkg::TIE_MAX
                                                                   : held[p].tie + 1'b1;
                        ties++;
                        if (e.tie > top_tie) top_tie = e.tie;
                    end
                    held.insert(p, e);
                    r.tie = e.tie;
                    r.pos = sqtn_pkg::OUT_POS_W'(p);
                end
            end else begin
                removes++;
                if (n == 0) begin
                    r.status = sqtn_pkg::ST_EMPTY;
                    empties++;
                end else begin
                    e = held.pop_front();
                    r.head_payload = e.payload;
                    r.tie = e.tie;
                end
            end
            r.count = sqtn_pkg::OUT_CNT_W'(held.size());
            awaited.push_back(r);
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            mismatches++;
            if (mismatches <= 100)
                $display("Mismatch on result %0d: %s is 0x%0h, expected 0x%0h.",
                         results, field, got, want);
        endtask

        task check_result(logic [1:0] st, logic [55:0] d);
            sqtn_pkg::t_res e;
            results++;
            if (awaited.size() == 0) begin
                report("unexpected transfer", 64'(d), 64'(0));
                return;
            end
            e = awaited.pop_front();
            if (st !== e.status) report("status", 64'(st), 64'(e.status));
            if (d[31:0] !== e.head_payload)
                report("head payload", 64'(d[31:0]), 64'(e.head_payload));
            if (d[37:32] !== e.tie) report("tie number", 64'(d[37:32]), 64'(e.tie));
            if (d[43:38] !== e.pos) report("insert position", 64'(d[43:38]), 64'(e.pos));
            if (d[44] !== e.eq) report("key equal flag", 64'(d[44]), 64'(e.eq));
            if (d[51:45] !== e.count) report("entry count", 64'(d[51:45]), 64'(e.count));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic [0:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    int send_idle_pct = 11;
    int recv_idle_pct = 78;

    queue_tracker sb = new();

    sorted_queue_with_tie_numbering DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_order(i_cfg_data);
            if (i_s_tvalid && o_s_tready)
                sb.note_request(sqtn_pkg::t_func'(i_s_tuser[0]), i_s_tdata[31:0],
                                i_s_tdata[63:32]);
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tuser, o_m_tdata);
        end
    end

    task automatic push_op(sqtn_pkg::t_func func, logic [31:0] key, logic [31:0] payload);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= func;
        i_s_tdata <= {payload, key};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_order(bit desc);
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= desc;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 12);
            5: return 32'h0000_0000;
            6: return 32'hFFFF_FFFF;
            7: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_burst(int count, int insert_pct);
        sqtn_pkg::t_func func;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 59) == 0) wait_drained();
            func = ($urandom_range(0, 99) < insert_pct) ? sqtn_pkg::FUNC_INSERT
                                                        : sqtn_pkg::FUNC_REMOVE;
            push_op(func, pick_key(), $urandom);
        end
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ascending order straight after reset.
        push_op(sqtn_pkg::FUNC_REMOVE, 32'h0, 32'h0);
        push_op(sqtn_pkg::FUNC_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        push_op(sqtn_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(sqtn_pkg::FUNC_INSERT, 32'h0000_0000, 32'h1234_5678);
        push_op(sqtn_pkg::FUNC_INSERT, 32'h0000_0000, 32'hA5A5_5A5A);
        push_op(sqtn_pkg::FUNC_INSERT, 32'h8000_0000, 32'h5A5A_A5A5);
        push_op(sqtn_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 32'h8000_0001);
        push_op(sqtn_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFE);
        for (int k = 0; k < 8; k++)
            push_op(sqtn_pkg::FUNC_REMOVE, $urandom, $urandom);

        // Descending order.
        write_order(1'b1);
        push_op(sqtn_pkg::FUNC_INSERT, 32'd5, $urandom);
        push_op(sqtn_pkg::FUNC_INSERT, 32'd9, $urandom);
        push_op(sqtn_pkg::FUNC_INSERT, 32'd5, $urandom);
        push_op(sqtn_pkg::FUNC_INSERT, 32'd0, $urandom);
        push_op(sqtn_pkg::FUNC_INSERT, 32'hFFFF_FFFF, $urandom);
        for (int k = 0; k < 6; k++)
            push_op(sqtn_pkg::FUNC_REMOVE, $urandom, $urandom);

        // Fill the table with one key to run the tie number up, then overflow it.
        for (int k = 0; k < sqtn_pkg::CAPACITY; k++)
            push_op(sqtn_pkg::FUNC_INSERT, 32'h2A, $urandom);
        push_op(sqtn_pkg::FUNC_INSERT, 32'h1, $urandom);
        push_op(sqtn_pkg::FUNC_INSERT, 32'hFFFF_FFFF, $urandom);

        // Flip the order while the table is full, then empty it completely.
        write_order(1'b0);
        push_op(sqtn_pkg::FUNC_INSERT, 32'h0, $urandom);
        for (int k = 0; k <= sqtn_pkg::CAPACITY; k++)
            push_op(sqtn_pkg::FUNC_REMOVE, $urandom, $urandom);

        for (int m = 0; m < 3; m++) begin
            wait_drained();
            send_idle_pct = (m == 0) ? 11 : (m == 1) ? 78 : 0;
            recv_idle_pct = (m == 0) ? 78 : (m == 1) ? 11 : 0;
            for (int s = 0; s < 2; s++) begin
                write_order(((m + s) % 2) == 0);
                random_burst(80, (s == 0) ? 75 : 40);
            end
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        $display("Ran %0d operations: %0d inserts (%0d tied, highest tie %0d), %0d removes.",
                 sb.inserts + sb.removes, sb.inserts, sb.ties, sb.top_tie, sb.removes);
        $display("Saw %0d full rejections and %0d empty removes across both key orders.",
                 sb.fulls, sb.empties);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
